@@ hdl/ecacd_pkg.sv @@
// Shared types, codes and constants for the column-density automaton block.
// Used by every module under hdl/ but ecacd_ram; depends on nothing else.
package ecacd_pkg;

    // Command kinds carried by the two-bit user field of an input transfer.
    typedef enum logic [1:0] {
        CMD_ADVANCE  = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_SEED     = 2'd2,
        CMD_SEED_RUN = 2'd3
    } cmd_kind_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RULE    = 2'd0;
    localparam logic [1:0] CFG_THRESH  = 2'd1;
    localparam logic [1:0] CFG_REVERSE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] RULE_RESET    = 8'd60;
    localparam logic [3:0] THRESH_RESET  = 4'd4;
    localparam logic       REVERSE_RESET = 1'b0;

    // Seeding keeps the even cells only and forces cell 0 alive.
    localparam logic [31:0] SEED_EVEN_MASK = 32'h5555_5555;
    localparam logic [31:0] SEED_FORCE     = 32'h0000_0001;
    localparam int          SEED_BITS      = 32;

    // Reported columns are limited to what a 5-bit position can name.
    localparam int MAX_OUT_COLS = 32;

    // Width that holds any count, threshold or span (up to 64 generations).
    localparam int CALC_W = 7;

    // Reciprocal scaling: q = (n * ceil(2^20 / span)) >> 20 is exact for n < 2^14.
    localparam int RECIP_FRAC = 20;
    localparam int RECIP_W    = 21;
    localparam int NUM_W      = 14;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    // Live configuration as seen by the back end.
    typedef struct packed {
        logic [7:0] rule_number;
        logic [3:0] density_threshold;
        logic       reverse_order;
    } cfg_t;

    // One classified command in the queue.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] seed;
    } cmd_t;

    // One column result.
    typedef struct packed {
        logic [4:0] column_index;
        logic [7:0] density;
        logic       newest_cell;
        logic       last_column;
    } res_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE,
        BK_EMIT
    } back_state_t;

    // ceil(2^20 / (span_m1 + 1)) for spans of 1 to 64.
    function automatic logic [RECIP_W-1:0] recip_lut(input logic [5:0] span_m1);
        logic [RECIP_W-1:0] r;
        case (span_m1)
            6'd0:  r = 21'd1048576;
            6'd1:  r = 21'd524288;
            6'd2:  r = 21'd349526;
            6'd3:  r = 21'd262144;
            6'd4:  r = 21'd209716;
            6'd5:  r = 21'd174763;
            6'd6:  r = 21'd149797;
            6'd7:  r = 21'd131072;
            6'd8:  r = 21'd116509;
            6'd9:  r = 21'd104858;
            6'd10: r = 21'd95326;
            6'd11: r = 21'd87382;
            6'd12: r = 21'd80660;
            6'd13: r = 21'd74899;
            6'd14: r = 21'd69906;
            6'd15: r = 21'd65536;
            6'd16: r = 21'd61681;
            6'd17: r = 21'd58255;
            6'd18: r = 21'd55189;
            6'd19: r = 21'd52429;
            6'd20: r = 21'd49933;
            6'd21: r = 21'd47663;
            6'd22: r = 21'd45591;
            6'd23: r = 21'd43691;
            6'd24: r = 21'd41944;
            6'd25: r = 21'd40330;
            6'd26: r = 21'd38837;
            6'd27: r = 21'd37450;
            6'd28: r = 21'd36158;
            6'd29: r = 21'd34953;
            6'd30: r = 21'd33826;
            6'd31: r = 21'd32768;
            6'd32: r = 21'd31776;
            6'd33: r = 21'd30841;
            6'd34: r = 21'd29960;
            6'd35: r = 21'd29128;
            6'd36: r = 21'd28340;
            6'd37: r = 21'd27595;
            6'd38: r = 21'd26887;
            6'd39: r = 21'd26215;
            6'd40: r = 21'd25576;
            6'd41: r = 21'd24967;
            6'd42: r = 21'd24386;
            6'd43: r = 21'd23832;
            6'd44: r = 21'd23302;
            6'd45: r = 21'd22796;
            6'd46: r = 21'd22311;
            6'd47: r = 21'd21846;
            6'd48: r = 21'd21400;
            6'd49: r = 21'd20972;
            6'd50: r = 21'd20561;
            6'd51: r = 21'd20165;
            6'd52: r = 21'd19785;
            6'd53: r = 21'd19419;
            6'd54: r = 21'd19066;
            6'd55: r = 21'd18725;
            6'd56: r = 21'd18397;
            6'd57: r = 21'd18079;
            6'd58: r = 21'd17773;
            6'd59: r = 21'd17477;
            6'd60: r = 21'd17190;
            6'd61: r = 21'd16913;
            6'd62: r = 21'd16645;
            6'd63: r = 21'd16384;
            default: r = 21'd16384;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/ecacd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instanced for the generation history rows.
module ecacd_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
)
(
    input  logic                                    clk,
    input  logic                                    wen,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    ren,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ecacd_front.sv @@
// Front end: takes input transfers, classifies the command and masks the seed.
// Depends on ecacd_pkg; feeds the command queue.
module ecacd_front
    import ecacd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] seed_row,
    output cmd_t        cmd,
    output logic        cmd_valid,
    input  logic        cmd_ready
);

    logic hold_valid_reg;
    cmd_t hold_cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic push;

    // Classify the command and keep only the seed bits that matter.
    always_comb
    begin
        cmd_next.kind = cmd_kind_t'(req_type);
        cmd_next.seed = (seed_row & SEED_EVEN_MASK) | SEED_FORCE;
    end

    assign push     = hold_valid_reg && cmd_ready;
    assign in_ready = !hold_valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    // Holding stage in front of the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= cmd_next;
        end
    end

    assign cmd       = hold_cmd_reg;
    assign cmd_valid = hold_valid_reg;

endmodule

@@ hdl/ecacd_cmd_fifo.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on ecacd_pkg for the command type and depth.
module ecacd_cmd_fifo
    import ecacd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t in_cmd,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t out_cmd,
    output logic out_valid,
    input  logic out_ready
);

    localparam int PTRW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNTW = $clog2(CMDQ_DEPTH + 1);

    cmd_t            slot_reg [CMDQ_DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [CNTW-1:0] fill_reg;
    logic            wr;
    logic            rd;

    assign in_ready  = (fill_reg != CNTW'(CMDQ_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;
    assign out_cmd   = slot_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hdl/ecacd_back.sv @@
// Back end: runs the automaton over the history RAM and emits one result per reported column.
// Depends on ecacd_pkg and ecacd_ram.
module ecacd_back
    import ecacd_pkg::*;
#(
    parameter int CELLS       = 32,
    parameter int GENERATIONS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_ready,
    output res_t res,
    output logic res_valid,
    input  logic res_ready
);

    localparam int OUT_COLS = (CELLS < MAX_OUT_COLS) ? CELLS : MAX_OUT_COLS;
    localparam int CLW      = $clog2(OUT_COLS);
    localparam int XW       = $clog2(CELLS);
    localparam int SW       = (GENERATIONS > 1) ? $clog2(GENERATIONS) : 1;
    localparam int CNTW     = $clog2(GENERATIONS + 1);
    localparam int STW      = $clog2(GENERATIONS + 1);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [SW-1:0]    newest_reg;
    logic [SW-1:0]    dst;
    logic [CELLS-1:0] cur_row_reg;
    logic [GENERATIONS-1:0] row_valid_reg;
    logic [CNTW-1:0]  cnt_reg [CELLS];
    logic [STW-1:0]   steps_reg;
    logic [CLW-1:0]   col_reg;
    res_t             res_reg;
    logic             res_valid_reg;

    logic [CELLS-1:0] seed_cells;
    logic [CELLS-1:0] next_row;
    logic [CELLS-1:0] old_row;
    logic [CELLS-1:0] ram_rdata;
    logic             ram_wen;
    logic [SW-1:0]    ram_waddr;
    logic [CELLS-1:0] ram_wdata;
    logic             ram_ren;

    logic start_clear;
    logic start_seed;
    logic pop;
    logic step_commit;
    logic issue;
    logic out_free;

    // Oldest-to-newest slot arithmetic: an advance writes the slot below the newest.
    assign dst = (newest_reg == '0) ? SW'(GENERATIONS - 1) : newest_reg - 1'b1;

    // Seed row over the ring; cells without a seed bit start dead.
    // Next generation from the newest row, one rule lookup per cell.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        localparam int LI = (i == 0) ? CELLS - 1 : i - 1;
        localparam int RI = (i + 1 == CELLS) ? 0 : i + 1;
        if (i < SEED_BITS)
        begin : g_seed
            assign seed_cells[i] = cmd.seed[i];
        end
        else
        begin : g_noseed
            assign seed_cells[i] = 1'b0;
        end
        assign next_row[i] = cfg.rule_number[{cur_row_reg[LI], cur_row_reg[i], cur_row_reg[RI]}];
    end

    // A row never written since the last clear or seed reads as all dead.
    assign old_row = row_valid_reg[dst] ? ram_rdata : '0;

    // History rows, one generation per entry.
    assign ram_wen   = start_seed || step_commit;
    assign ram_waddr = start_seed ? newest_reg : dst;
    assign ram_wdata = start_seed ? seed_cells : next_row;
    assign ram_ren   = (state_reg == BK_READ);

    ecacd_ram #(
        .WIDTH (CELLS),
        .DEPTH (GENERATIONS)
    ) u_hist_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (dst),
        .rdata (ram_rdata)
    );

    assign out_free = !res_valid_reg || res_ready;

    // Sequencer: next state and control strobes.
    always_comb
    begin
        state_next  = state_reg;
        start_clear = 1'b0;
        start_seed  = 1'b0;
        pop         = 1'b0;
        step_commit = 1'b0;
        issue       = 1'b0;
        cmd_ready   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    case (cmd.kind)
                        CMD_ADVANCE:
                        begin
                            state_next = BK_READ;
                        end
                        CMD_CLEAR:
                        begin
                            start_clear = 1'b1;
                            state_next  = BK_EMIT;
                        end
                        CMD_SEED:
                        begin
                            start_seed = 1'b1;
                            state_next = BK_EMIT;
                        end
                        CMD_SEED_RUN:
                        begin
                            start_seed = 1'b1;
                            state_next = BK_READ;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                state_next = BK_WRITE;
            end
            BK_WRITE:
            begin
                step_commit = 1'b1;
                state_next  = (steps_reg == STW'(1)) ? BK_EMIT : BK_READ;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    issue = 1'b1;
                    if (col_reg == CLW'(OUT_COLS - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Automaton state: newest row, row valid bits and per-column live counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg    <= '0;
            cur_row_reg   <= '0;
            row_valid_reg <= '0;
            steps_reg     <= '0;
            col_reg       <= '0;
            for (int i = 0; i < CELLS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                steps_reg <= (cmd.kind == CMD_ADVANCE) ? STW'(1) : STW'(GENERATIONS);
                col_reg   <= '0;
            end
            if (start_clear || start_seed)
            begin
                // A seed leaves only the newest row valid; a clear leaves none.
                row_valid_reg <= start_seed ? (GENERATIONS'(1) << newest_reg) : '0;
                cur_row_reg   <= start_seed ? seed_cells : '0;
                for (int i = 0; i < CELLS; i++)
                begin
                    cnt_reg[i] <= start_seed ? CNTW'(seed_cells[i]) : '0;
                end
            end
            if (step_commit)
            begin
                row_valid_reg[dst] <= 1'b1;
                cur_row_reg        <= next_row;
                newest_reg         <= dst;
                steps_reg          <= steps_reg - 1'b1;
                for (int i = 0; i < CELLS; i++)
                begin
                    cnt_reg[i] <= cnt_reg[i] + CNTW'(next_row[i]) - CNTW'(old_row[i]);
                end
            end
            if (issue)
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Density of the current column: 255 * (ones - th) times the span reciprocal.
    logic [XW-1:0]         col_x;
    logic [CALC_W-1:0]     ones;
    logic [CALC_W-1:0]     th;
    logic [CALC_W-1:0]     gens;
    logic [CALC_W-1:0]     diff;
    logic [CALC_W-1:0]     span;
    logic                  active;
    logic [NUM_W-1:0]      num;
    logic [RECIP_W-1:0]    recip;
    logic [NUM_W+RECIP_W-1:0] prod;
    logic [CALC_W-1:0]     pos;
    res_t                  res_next;

    assign col_x  = XW'(col_reg);
    assign ones   = CALC_W'(cnt_reg[col_x]);
    assign th     = CALC_W'(cfg.density_threshold);
    assign gens   = CALC_W'(GENERATIONS);
    assign active = (th < gens) && (ones > th);
    assign diff   = ones - th;
    assign span   = gens - th;
    assign recip  = recip_lut(6'(span - 1'b1));
    assign num    = active ? NUM_W'({diff, 8'b0} - {8'b0, diff}) : '0;
    assign prod   = num * recip;
    assign pos    = cfg.reverse_order ? CALC_W'(CELLS - 1) - CALC_W'(col_reg)
                                      : CALC_W'(col_reg);

    always_comb
    begin
        res_next.column_index = pos[4:0];
        res_next.density      = prod[RECIP_FRAC+7:RECIP_FRAC];
        res_next.newest_cell  = cur_row_reg[col_x];
        res_next.last_column  = (col_reg == CLW'(OUT_COLS - 1));
    end

    // Output register; the back end keeps issuing while the consumer takes results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

@@ hdl/elementary_ca_column_density_top.sv @@
// Elementary cellular automaton with per-column density results. A command leaves the
// queue, each automaton step reads the history RAM and then writes back, and the
// reported columns, min(CELLS,32) of them, are emitted in turn while the output is taken:
// an advance makes one step, a seed-and-run seeds and makes GENERATIONS steps, and a
// clear or seed makes none. The front end and a two-entry command queue take new
// commands while the back end works. Configuration is not latched per command; the back
// end reads the live configuration registers.
//
// Top level: configuration registers, front end, command queue and back end.
// Depends on ecacd_pkg, ecacd_front, ecacd_cmd_fifo, ecacd_back and ecacd_ram.
module elementary_ca_column_density_top
    import ecacd_pkg::*;
#(
    parameter int CELLS       = 32,
    parameter int GENERATIONS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_row
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    // Column result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] column_index, [12:5] density,
                                        // [13] newest_cell, [15:14] zero
    output logic        m_axis_tlast,   // last_column
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t cfg_reg;
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t queue_cmd;
    logic queue_valid;
    logic queue_ready;
    res_t res;

    // Configuration registers; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rule_number       <= RULE_RESET;
            cfg_reg.density_threshold <= THRESH_RESET;
            cfg_reg.reverse_order     <= REVERSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RULE:    cfg_reg.rule_number       <= cfg_data;
                CFG_THRESH:  cfg_reg.density_threshold <= cfg_data[3:0];
                CFG_REVERSE: cfg_reg.reverse_order     <= cfg_data[0];
                default:     cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Command intake and classification.
    ecacd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req_type  (s_axis_tuser),
        .seed_row  (s_axis_tdata),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // Queue between front and back.
    ecacd_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (queue_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    // Automaton engine and column emitter.
    ecacd_back #(
        .CELLS       (CELLS),
        .GENERATIONS (GENERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .res       (res),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready)
    );

    // Pack the result fields onto the stream.
    assign m_axis_tdata = {2'b00, res.newest_cell, res.density, res.column_index};
    assign m_axis_tlast = res.last_column;

endmodule
